/* hdl/assert_macros.svh */
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never hold on a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

/* hdl/tafl_pkg.sv */
// Package with constants, coefficient table and shared types of the low-pass filter.
`default_nettype none

package tafl_pkg;

	localparam int AXES            = 3;
	localparam int TAPS_DEF        = 20;
	localparam int FRAC_BITS_DEF   = 23;
	localparam int SAMPLE_BITS_DEF = 10;

	localparam int WEIGHT_COUNT = 20;
	localparam int WEIGHT_BITS  = 22;
	localparam int WIDX_BITS    = $clog2(WEIGHT_COUNT);

	localparam int OUT_BITS = 11;
	localparam int OUT_MAX  = 1023;
	localparam int OUT_MIN  = -1024;

	// Symmetric Q23 low-pass weights, tap 0 applies to the newest sample.
	localparam logic signed [WEIGHT_BITS-1:0] LP_WEIGHT [WEIGHT_COUNT] = '{
		22'sd0,        -22'sd17803,  -22'sd53061,  -22'sd97407,  -22'sd103638,
		22'sd0,        22'sd266544,  22'sd683134,  22'sd1153381, 22'sd1527779,
		22'sd1670749,  22'sd1527779, 22'sd1153381, 22'sd683134,  22'sd266544,
		22'sd0,        -22'sd103638, -22'sd97407,  -22'sd53061,  -22'sd17803
	};

	// Weight of tap k; taps past the end of the table weigh zero.
	function automatic logic signed [WEIGHT_BITS-1:0] tap_weight(input int k);
		logic signed [WEIGHT_BITS-1:0] w;
		w = '0;
		if (k >= 0 && k < WEIGHT_COUNT) begin
			w = LP_WEIGHT[k[WIDX_BITS-1:0]];
		end
		return w;
	endfunction

	// Control from the sequencer to each multiply-accumulate lane.
	typedef struct packed {
		logic mac_valid;
		logic first;
		logic last;
		logic load;
	} tafl_ctl_t;

endpackage

`default_nettype wire

/* hdl/tafl_in_if.sv */
// Input channel carrying one sample word for all three axes.
`default_nettype none

interface tafl_in_if import tafl_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] x_sample;
	logic signed [SAMPLE_BITS-1:0] y_sample;
	logic signed [SAMPLE_BITS-1:0] z_sample;

	modport source (output valid, output x_sample, output y_sample, output z_sample,
		input ready);
	modport sink (input valid, input x_sample, input y_sample, input z_sample,
		output ready);

endinterface

`default_nettype wire

/* hdl/tafl_out_if.sv */
// Output channel carrying one filtered word for all three axes.
`default_nettype none

interface tafl_out_if import tafl_pkg::*; ();

	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] x_filtered;
	logic signed [OUT_BITS-1:0] y_filtered;
	logic signed [OUT_BITS-1:0] z_filtered;

	modport source (output valid, output x_filtered, output y_filtered,
		output z_filtered, input ready);
	modport sink (input valid, input x_filtered, input y_filtered, input z_filtered,
		output ready);

endinterface

`default_nettype wire

/* hdl/three_axis_fir_lowpass_core.sv */
// Three-axis low-pass FIR core: per-axis rotating delay line and one shared MAC lane per axis.
// Each accepted sample word passes the tap walk, product register, accumulator and output register.
// Throughput is set by the single multiply-accumulate per axis: a new word waits for the last load.
// A finished word waits in the output register while the next sample word is taken.
// Reset clears the delay lines to zero, the sequencer to idle and the output valid flag.
`default_nettype none
`include "assert_macros.svh"

module three_axis_fir_lowpass_core import tafl_pkg::*; #(
	parameter int TAPS        = TAPS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tafl_in_if.sink    samples,
	tafl_out_if.source filtered
);

	localparam int K_W = $clog2(TAPS);
	localparam logic [K_W-1:0] K_LAST = K_W'(TAPS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_WAIT
	} state_t;

	state_t                        state_q;
	logic [K_W-1:0]                k_q;
	logic                          out_valid_q;
	logic                          accept;
	logic                          walking;
	tafl_ctl_t                     ctl;
	logic signed [WEIGHT_BITS-1:0] wgt;
	logic signed [SAMPLE_BITS-1:0] smp_in [AXES];
	logic signed [SAMPLE_BITS-1:0] hist_q [AXES][TAPS];
	logic                          fin    [AXES];
	logic signed [OUT_BITS-1:0]    filt   [AXES];

	// The core takes a new sample word only while the sequencer is idle.
	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign walking       = (state_q == ST_WALK);

	assign smp_in[0] = samples.x_sample;
	assign smp_in[1] = samples.y_sample;
	assign smp_in[2] = samples.z_sample;

	// Entry k of each delay line holds the sample k words old, the current
	// word sitting at entry 0 once it is accepted. During the walk the line
	// rotates by one entry per cycle so the lane always reads entry 0; after
	// TAPS rotations every sample is back at its place. The oldest entry falls
	// off the end when the next word is shifted in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				for (int i = 0; i < TAPS; i++) begin
					hist_q[a][i] <= '0;
				end
			end
		end else if (accept) begin
			for (int a = 0; a < AXES; a++) begin
				hist_q[a][0] <= smp_in[a];
				for (int i = 1; i < TAPS; i++) begin
					hist_q[a][i] <= hist_q[a][i-1];
				end
			end
		end else if (walking) begin
			for (int a = 0; a < AXES; a++) begin
				for (int i = 0; i < TAPS - 1; i++) begin
					hist_q[a][i] <= hist_q[a][i+1];
				end
				hist_q[a][TAPS-1] <= hist_q[a][0];
			end
		end
	end

	// Sequencer: walk the taps, wait for the lanes to finish their sums, then
	// load the scaled results into the output register as soon as the
	// previous word there has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				out_valid_q <= 1'b1;
			end else if (filtered.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WALK;
						k_q     <= '0;
					end
				end
				ST_WALK: begin
					if (k_q == K_LAST) begin
						state_q <= ST_WAIT;
						k_q     <= '0;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (ctl.load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign wgt           = tap_weight(int'(k_q));
	assign ctl.mac_valid = walking;
	assign ctl.first     = (k_q == '0);
	assign ctl.last      = (k_q == K_LAST);
	assign ctl.load      = (state_q == ST_WAIT) && fin[0] && (!out_valid_q || filtered.ready);

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		tafl_mac #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.FRAC_BITS   (FRAC_BITS)
		) u_mac (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.smp    (hist_q[a][0]),
			.wgt    (wgt),
			.fin    (fin[a]),
			.filt   (filt[a])
		);
	end

	assign filtered.valid      = out_valid_q;
	assign filtered.x_filtered = filt[0];
	assign filtered.y_filtered = filt[1];
	assign filtered.z_filtered = filt[2];

	`ASSERT_CLK(a_walk_ends, (walking && k_q == K_LAST) |=> (state_q == ST_WAIT), "walk overran")
	`ASSERT_CLK(a_lanes_agree, (fin[0] == fin[1]) && (fin[1] == fin[2]), "lanes out of step")
	`ASSERT_CLK(a_cnt_home, !walking |-> (k_q == '0), "tap counter not home outside walk")

endmodule

`default_nettype wire

/* hdl/tafl_mac.sv */
// One axis lane: registered multiply, accumulate, then scale and saturate.
`default_nettype none
`include "assert_macros.svh"

module tafl_mac import tafl_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tafl_ctl_t                     ctl,
	input  logic signed [SAMPLE_BITS-1:0] smp,
	input  logic signed [WEIGHT_BITS-1:0] wgt,
	output logic                          fin,
	output logic signed [OUT_BITS-1:0]    filt
);

	localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS;
	localparam int ACC_W  = PROD_W + WIDX_BITS;
	localparam logic signed [ACC_W-1:0] BIAS =
		{{(ACC_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
	localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(OUT_MAX);
	localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(OUT_MIN);

	logic signed [PROD_W-1:0]   prod_s1;
	logic                       v_s1;
	logic                       first_s1;
	logic                       last_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       fin_q;
	logic signed [OUT_BITS-1:0] filt_q;
	logic signed [ACC_W-1:0]    quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			fin_q    <= 1'b0;
		end else begin
			v_s1     <= ctl.mac_valid;
			first_s1 <= ctl.first;
			last_s1  <= ctl.last;
			if (ctl.load) begin
				fin_q <= 1'b0;
			end else if (v_s1 && last_s1) begin
				fin_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mac_valid) begin
			prod_s1 <= smp * wgt;
		end
		if (v_s1) begin
			acc_q <= (first_s1 ? '0 : acc_q) + ACC_W'(prod_s1);
		end
		if (ctl.load) begin
			if (quot > Q_MAX) begin
				filt_q <= OUT_BITS'(Q_MAX);
			end else if (quot < Q_MIN) begin
				filt_q <= OUT_BITS'(Q_MIN);
			end else begin
				filt_q <= OUT_BITS'(quot);
			end
		end
	end

	// Division by a power of two truncating toward zero: bias negatives first.
	always_comb begin
		quot = $signed(acc_q + (acc_q[ACC_W-1] ? BIAS : '0)) >>> FRAC_BITS;
	end

	assign fin  = fin_q;
	assign filt = filt_q;

	`ASSERT_CLK(a_load_final, ctl.load |-> fin_q, "lane result loaded before it was final")
	`ASSERT_CLK(a_fin_after_last, (v_s1 && last_s1) |=> fin_q, "last product did not finish sum")
	`ASSERT_NEVER(a_walk_over_result, ctl.mac_valid && fin_q, "new walk over an unloaded sum")

endmodule

`default_nettype wire
